FILE: design/assert_macros.svh
// Assertion macros shared by the detector RTL.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FDT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fdt assertion failed");

// next-cycle implication
`define FDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fdt assertion failed");

`endif

FILE: design/fdt_pkg.sv
// Shared types, constants and functions of the force double-tap detector.
// No dependencies; used by every other RTL file.
`default_nettype none

package fdt_pkg;

  localparam int FORCE_BITS    = 16;
  localparam int AXES          = 3;
  localparam int ABS_BITS      = 16;
  localparam int SQ_BITS       = 31;
  localparam int D2_BITS       = 32;
  localparam int TH_BITS       = 15;
  localparam int TH2_BITS      = 2 * TH_BITS;
  localparam int CNT_BITS      = 16;
  localparam int TAP_BITS      = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int WIDE_BITS     = (FORCE_BITS > ABS_BITS) ? FORCE_BITS + 1 : ABS_BITS + 1;

  localparam logic [ABS_BITS-1:0] ABS_CAP    = {1'b1, {(ABS_BITS-1){1'b0}}};
  localparam logic [TAP_BITS-1:0] TAPS_DONE  = TAP_BITS'(2);
  localparam logic [CNT_BITS-1:0] CNT_MAX    = '1;
  localparam logic [TH2_BITS-1:0] PRESS2_RST = TH2_BITS'(128 * 128);
  localparam logic [TH2_BITS-1:0] RELEASE2_RST = TH2_BITS'(64 * 64);
  localparam logic [CNT_BITS-1:0] WINDOW_RST = CNT_BITS'(500);
  localparam logic [CNT_BITS-1:0] REBASE_RST = CNT_BITS'(2000);

  typedef enum logic {
    CMD_START  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PRESS_TH   = 2'd0,
    REG_RELEASE_TH = 2'd1,
    REG_WINDOW     = 2'd2,
    REG_REBASE     = 2'd3
  } cfg_reg_t;

  typedef logic [AXES-1:0][FORCE_BITS-1:0] force_vec_t;
  typedef logic [AXES-1:0][SQ_BITS-1:0]    sq_vec_t;

  typedef struct packed {
    cmd_t       cmd;
    force_vec_t frc;
    sq_vec_t    sq;
  } beat_t;

  typedef struct packed {
    logic       rebase;
    force_vec_t base;
  } base_t;

  // squared per-axis deviation; magnitude capped at 2^15, beyond any threshold
  function automatic logic [SQ_BITS-1:0] dev_sq(logic [FORCE_BITS-1:0] f,
                                                logic [FORCE_BITS-1:0] b);
    logic signed [FORCE_BITS:0] fs;
    logic signed [FORCE_BITS:0] bs;
    logic signed [FORCE_BITS:0] d;
    logic [FORCE_BITS:0]        mag;
    logic [WIDE_BITS-1:0]       m;
    logic [ABS_BITS-1:0]        a;
    logic [2*ABS_BITS-1:0]      aw;
    logic [2*ABS_BITS-1:0]      p;
    fs  = $signed(f);
    bs  = $signed(b);
    d   = fs - bs;
    mag = d[FORCE_BITS] ? (~d + 1'b1) : d;
    m   = WIDE_BITS'(mag);
    a   = (m > WIDE_BITS'(ABS_CAP)) ? ABS_CAP : m[ABS_BITS-1:0];
    aw  = (2*ABS_BITS)'(a);
    p   = aw * aw;
    return p[SQ_BITS-1:0];
  endfunction

  function automatic logic [CNT_BITS-1:0] sat_inc(logic [CNT_BITS-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

FILE: design/fdt_capture.sv
// Input stage: registers the beat together with its squared per-axis deviations.
// Depends on fdt_pkg and assert_macros.svh; fed the baseline by fdt_update.
`default_nettype none
`include "assert_macros.svh"

module fdt_capture (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fdt_pkg::cmd_t      in_cmd,
  input  fdt_pkg::force_vec_t in_frc,
  input  fdt_pkg::base_t     base,
  input  logic               take,
  output logic               cap_valid,
  output fdt_pkg::beat_t     beat
);
  import fdt_pkg::*;

  logic       cap_valid_r, cap_valid_nxt;
  logic       cap_stale_r, cap_stale_nxt;
  beat_t      beat_r, beat_nxt;
  logic       load;
  force_vec_t src_frc;
  sq_vec_t    sq;

  assign in_ready  = !cap_valid_r || take;
  assign load      = in_valid && in_ready;
  assign cap_valid = cap_valid_r && !cap_stale_r;
  assign beat      = beat_r;

  // a stale beat is recomputed in place against the new baseline
  assign src_frc = load ? in_frc : beat_r.frc;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      sq[i] = dev_sq(src_frc[i], base.base[i]);
    end
    beat_nxt.cmd  = load ? in_cmd : beat_r.cmd;
    beat_nxt.frc  = src_frc;
    beat_nxt.sq   = sq;
    cap_valid_nxt = load ? 1'b1 : (take ? 1'b0 : cap_valid_r);
    cap_stale_nxt = load && base.rebase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_valid_r <= 1'b0;
      cap_stale_r <= 1'b0;
    end else begin
      cap_valid_r <= cap_valid_nxt;
      cap_stale_r <= cap_stale_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load || cap_stale_r) begin
      beat_r <= beat_nxt;
    end
  end

  `FDT_ASSERT_NOW(a_stale_held, cap_stale_r, cap_valid_r && !take)
  `FDT_ASSERT_NEXT(a_stale_one_cycle, cap_stale_r, !cap_stale_r && cap_valid_r)

endmodule

`default_nettype wire

FILE: design/fdt_update.sv
// Detector state, configuration registers and result register.
// Depends on fdt_pkg and assert_macros.svh; consumes beats from fdt_capture.
`default_nettype none
`include "assert_macros.svh"

module fdt_update (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [fdt_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [fdt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 cap_valid,
  input  fdt_pkg::beat_t                       beat,
  output logic                                 take,
  output fdt_pkg::base_t                       base,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_done_res,
  output logic [fdt_pkg::TAP_BITS-1:0]         out_tap_count,
  output logic                                 out_armed
);
  import fdt_pkg::*;

  logic [TH2_BITS-1:0] p2_r, r2_r;
  logic [CNT_BITS-1:0] tw_r, rb_r;
  logic [TH2_BITS-1:0] th_w, th_sq;

  force_vec_t          base_r, base_nxt;
  logic [TAP_BITS-1:0] taps_r, taps_nxt;
  logic                allowed_r, allowed_nxt;
  logic [CNT_BITS-1:0] sp_r, sp_nxt;
  logic [CNT_BITS-1:0] sa_r, sa_nxt;
  logic                fin_r, fin_nxt;
  logic                change;
  logic                pressed, released;
  logic [D2_BITS-1:0]  d2;

  logic                out_valid_r;
  logic                done_r;
  logic [TAP_BITS-1:0] tap_r;
  logic                armed_r;

  assign th_w  = TH2_BITS'(cfg_data[TH_BITS-1:0]);
  assign th_sq = th_w * th_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_r <= PRESS2_RST;
      r2_r <= RELEASE2_RST;
      tw_r <= WINDOW_RST;
      rb_r <= REBASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PRESS_TH:   p2_r <= th_sq;
        REG_RELEASE_TH: r2_r <= th_sq;
        REG_WINDOW:     tw_r <= cfg_data[CNT_BITS-1:0];
        REG_REBASE:     rb_r <= cfg_data[CNT_BITS-1:0];
      endcase
    end
  end

  assign take = cap_valid && (!out_valid_r || out_ready);
  assign d2   = D2_BITS'(beat.sq[0]) + D2_BITS'(beat.sq[1]) + D2_BITS'(beat.sq[2]);

  always_comb begin
    base_nxt    = base_r;
    taps_nxt    = taps_r;
    allowed_nxt = allowed_r;
    sp_nxt      = sp_r;
    sa_nxt      = sa_r;
    fin_nxt     = fin_r;
    change      = 1'b0;
    pressed     = 1'b0;
    released    = 1'b0;
    if (take) begin
      if (beat.cmd == CMD_START) begin
        base_nxt    = beat.frc;
        taps_nxt    = '0;
        allowed_nxt = 1'b1;
        sp_nxt      = '0;
        sa_nxt      = '0;
        fin_nxt     = 1'b0;
        change      = 1'b1;
      end else if (!fin_r) begin
        pressed = allowed_r && (d2 > D2_BITS'(p2_r));
        if (pressed) begin
          if (taps_r < TAPS_DONE) begin
            taps_nxt = TAP_BITS'(taps_r + 1'b1);
          end
          allowed_nxt = 1'b0;
        end
        released = (taps_nxt != '0) && (d2 < D2_BITS'(r2_r));
        if (released) begin
          allowed_nxt = 1'b1;
        end
        sp_nxt = pressed ? '0 : sat_inc(sp_r);
        sa_nxt = (pressed || released) ? '0 : sat_inc(sa_r);
        if (sp_nxt > tw_r) begin
          taps_nxt = '0;
        end
        if (sa_nxt > rb_r) begin
          base_nxt = beat.frc;
          sa_nxt   = '0;
          change   = 1'b1;
        end
        if (taps_nxt >= TAPS_DONE) begin
          fin_nxt = 1'b1;
        end
      end
    end
  end

  assign base.rebase = change;
  assign base.base   = base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      taps_r      <= '0;
      allowed_r   <= 1'b1;
      sp_r        <= '0;
      sa_r        <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      taps_r      <= taps_nxt;
      allowed_r   <= allowed_nxt;
      sp_r        <= sp_nxt;
      sa_r        <= sa_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      done_r  <= fin_nxt;
      tap_r   <= taps_nxt;
      armed_r <= allowed_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_done_res  = done_r;
  assign out_tap_count = tap_r;
  assign out_armed     = armed_r;

  `FDT_ASSERT_NOW(a_done_two_taps, fin_r, taps_r == TAPS_DONE)
  `FDT_ASSERT_NEXT(a_start_clears, take && beat.cmd == CMD_START,
                   !fin_r && allowed_r && taps_r == '0)

endmodule

`default_nettype wire

FILE: design/force_double_tap_detector.sv
// Top level of the force double-tap detector.
// Depends on fdt_pkg, fdt_capture and fdt_update.
//
// One beat is accepted per clock while in_ready is high; it passes through the
// capture register into the output register. While the output is stalled the
// capture register holds one more beat, and after that in_ready drops until the
// result beat is taken. The capture stage squares the three per-axis deviations
// from the baseline in its multipliers; the update stage sums them, compares
// against the squared thresholds and advances the tap state. A beat captured in
// the same cycle that a start or a baseline re-capture is applied is held in the
// capture register while its squares are redone against the new baseline in the
// capture multipliers. Threshold squares are formed when the register is written.
// No clearing pass after reset.
`default_nettype none

module force_double_tap_detector (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic signed [fdt_pkg::FORCE_BITS-1:0] in_force_x,
  input  logic signed [fdt_pkg::FORCE_BITS-1:0] in_force_y,
  input  logic signed [fdt_pkg::FORCE_BITS-1:0] in_force_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_done_res,
  output logic [fdt_pkg::TAP_BITS-1:0]          out_tap_count,
  output logic                                  out_armed,
  input  logic                                  cfg_we,
  input  logic [fdt_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [fdt_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import fdt_pkg::*;

  force_vec_t in_frc;
  cmd_t       in_cmd;
  base_t      base;
  beat_t      beat;
  logic       take;
  logic       cap_valid;

  assign in_frc[0] = in_force_x;
  assign in_frc[1] = in_force_y;
  assign in_frc[2] = in_force_z;
  assign in_cmd    = cmd_t'(in_command);

  fdt_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_frc    (in_frc),
    .base      (base),
    .take      (take),
    .cap_valid (cap_valid),
    .beat      (beat)
  );

  fdt_update u_update (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cap_valid     (cap_valid),
    .beat          (beat),
    .take          (take),
    .base          (base),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_done_res  (out_done_res),
    .out_tap_count (out_tap_count),
    .out_armed     (out_armed)
  );

endmodule

`default_nettype wire

FILE: tb/force_double_tap_detector_tb.sv
// Self-checking testbench for force_double_tap_detector: directed and random force beats.
// The tap state is predicted in-line and compared per result beat with random idling.
// Depends on fdt_pkg and the detector RTL.
`timescale 1ns / 1ps

module force_double_tap_detector_tb;
  import fdt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic       done;
    logic [1:0] taps;
    logic       armed;
  } tap_result_t;

  typedef enum int {
    KIND_QUIET,
    KIND_MID,
    KIND_PRESS,
    KIND_NOISE
  } sample_kind_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic signed [15:0] in_force_x = '0;
  logic signed [15:0] in_force_y = '0;
  logic signed [15:0] in_force_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_done_res;
  logic [1:0] out_tap_count;
  logic out_armed;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  force_double_tap_detector DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_force_x   (in_force_x),
    .in_force_y   (in_force_y),
    .in_force_z   (in_force_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_done_res (out_done_res),
    .out_tap_count(out_tap_count),
    .out_armed    (out_armed),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted detector state and registers
  logic [14:0]        press_th;
  logic [14:0]        release_th;
  logic [15:0]        window_ticks;
  logic [15:0]        rebase_ticks;
  logic signed [15:0] base_frc [3];
  logic [1:0]         tap_cnt;
  logic               press_ok;
  logic [15:0]        ticks_since_press;
  logic [15:0]        ticks_quiet;
  logic               double_tap;

  tap_result_t expected_taps_q [$];
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  int          stall_left = 0;

  function automatic logic [15:0] bump16(logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic predict_tap_state(input cmd_t cmd, input logic signed [15:0] fx,
                                   input logic signed [15:0] fy,
                                   input logic signed [15:0] fz);
    logic signed [15:0] f [3];
    longint             diff;
    longint unsigned    d2;
    longint unsigned    p2;
    longint unsigned    r2;
    bit                 pressed;
    bit                 released;
    tap_result_t        res;
    f[0] = fx;
    f[1] = fy;
    f[2] = fz;
    if (cmd == CMD_START) begin
      for (int i = 0; i < 3; i++) base_frc[i] = f[i];
      tap_cnt = 2'd0;
      press_ok = 1'b1;
      ticks_since_press = '0;
      ticks_quiet = '0;
      double_tap = 1'b0;
    end else if (!double_tap) begin
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        diff = longint'(base_frc[i]) - longint'(f[i]);
        if (diff < 0) diff = -diff;
        d2 += longint'(diff) * longint'(diff);
      end
      p2 = longint'(press_th) * longint'(press_th);
      r2 = longint'(release_th) * longint'(release_th);
      pressed = 1'b0;
      released = 1'b0;
      if (press_ok && d2 > p2) begin
        if (tap_cnt < 2'd2) tap_cnt = tap_cnt + 2'd1;
        press_ok = 1'b0;
        pressed = 1'b1;
      end
      if (tap_cnt > 2'd0 && d2 < r2) begin
        press_ok = 1'b1;
        released = 1'b1;
      end
      ticks_since_press = pressed ? 16'd0 : bump16(ticks_since_press);
      ticks_quiet = (pressed || released) ? 16'd0 : bump16(ticks_quiet);
      if (ticks_since_press > window_ticks) tap_cnt = 2'd0;
      if (ticks_quiet > rebase_ticks) begin
        for (int i = 0; i < 3; i++) base_frc[i] = f[i];
        ticks_quiet = '0;
      end
      if (tap_cnt >= 2'd2) double_tap = 1'b1;
    end
    res.done = double_tap;
    res.taps = tap_cnt;
    res.armed = press_ok;
    expected_taps_q.push_back(res);
  endtask

  // called just after a falling edge; returns just after a falling edge with the beat taken
  task automatic send_beat(input cmd_t cmd, input logic signed [15:0] fx,
                           input logic signed [15:0] fy, input logic signed [15:0] fz);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_force_x <= fx;
    in_force_y <= fy;
    in_force_z <= fz;
    predict_tap_state(cmd, fx, fy, fz);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_taps_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PRESS_TH:   press_th = val[14:0];
      REG_RELEASE_TH: release_th = val[14:0];
      REG_WINDOW:     window_ticks = val;
      REG_REBASE:     rebase_ticks = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all_regs(input logic [15:0] p, input logic [15:0] r,
                                input logic [15:0] w, input logic [15:0] q);
    wait_drained();
    write_reg(REG_PRESS_TH, p);
    write_reg(REG_RELEASE_TH, r);
    write_reg(REG_WINDOW, w);
    write_reg(REG_REBASE, q);
  endtask

  // force relative to the predicted baseline, or fully random for noise beats
  task automatic pick_force(input sample_kind_t kind, output logic signed [15:0] fx,
                            output logic signed [15:0] fy, output logic signed [15:0] fz);
    longint off [3];
    int     r;
    int     m;
    int     ax;
    for (int i = 0; i < 3; i++) off[i] = 0;
    case (kind)
      KIND_QUIET: begin
        r = release_th / 2;
        for (int i = 0; i < 3; i++) off[i] = int'($urandom_range(0, 2 * r)) - r;
      end
      KIND_MID: begin
        m = (int'(release_th) + int'(press_th)) / 2;
        ax = $urandom_range(0, 2);
        off[ax] = $urandom_range(0, 1) ? m : -m;
      end
      KIND_PRESS: begin
        m = int'(press_th) * 3 / 5;
        for (int i = 0; i < 3; i++) begin
          r = m + int'($urandom_range(1, 50));
          off[i] = $urandom_range(0, 1) ? r : -r;
        end
      end
      default: ;
    endcase
    if (kind == KIND_NOISE) begin
      fx = 16'($urandom());
      fy = 16'($urandom());
      fz = 16'($urandom());
    end else begin
      fx = clamp16(longint'(base_frc[0]) + off[0]);
      fy = clamp16(longint'(base_frc[1]) + off[1]);
      fz = clamp16(longint'(base_frc[2]) + off[2]);
    end
  endtask

  task automatic send_kind(input sample_kind_t kind);
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] fz;
    pick_force(kind, fx, fy, fz);
    send_beat(CMD_SAMPLE, fx, fy, fz);
  endtask

  task automatic test_reset_defaults();
    write_all_regs(16'd128, 16'd64, 16'd500, 16'd2000);
    send_beat(CMD_SAMPLE, 16'sd200, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd100, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd0, -16'sd150, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd900, 16'sd0, 16'sd900);
    send_beat(CMD_START, 16'sd10, 16'sd20, 16'sd30);
  endtask

  task automatic test_force_extremes();
    write_all_regs(16'd32767, 16'd32767, 16'd65535, 16'd65535);
    send_beat(CMD_START, -16'sd32768, -16'sd32768, -16'sd32768);
    send_beat(CMD_SAMPLE, 16'sd32767, 16'sd32767, 16'sd32767);
    send_beat(CMD_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768);
    send_beat(CMD_SAMPLE, 16'sd32767, 16'sd32767, 16'sd32767);
    send_beat(CMD_SAMPLE, 16'sh5555, 16'shAAAA, 16'sh5555);
    send_beat(CMD_START, 16'sd32767, -16'sd32768, 16'sd0);
    send_beat(CMD_SAMPLE, -16'sd32768, 16'sd32767, 16'shAAAA);
  endtask

  task automatic test_zero_windows();
    write_all_regs(16'd100, 16'd50, 16'd0, 16'd0);
    send_beat(CMD_START, 16'sd0, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd200, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd75, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd75, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd300, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
    write_all_regs(16'd0, 16'd0, 16'd3, 16'd2);
    send_beat(CMD_START, 16'sd5, 16'sd5, 16'sd5);
    send_beat(CMD_SAMPLE, 16'sd5, 16'sd5, 16'sd6);
    send_beat(CMD_SAMPLE, 16'sd5, 16'sd5, 16'sd5);
    send_beat(CMD_SAMPLE, 16'sd7, 16'sd5, 16'sd5);
  endtask

  task automatic run_tap_sequences(input int beats);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < beats) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0)
        send_beat(CMD_START, 16'($urandom()), 16'($urandom()), 16'($urandom()));
      else
        send_beat(CMD_START, clamp16(longint'($urandom_range(0, 4000)) - 2000),
                  clamp16(longint'($urandom_range(0, 4000)) - 2000),
                  clamp16(longint'($urandom_range(0, 4000)) - 2000));
      sent++;
      len = $urandom_range(4, 40);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) send_kind(KIND_PRESS);
        else if (pick < 60) send_kind(KIND_QUIET);
        else if (pick < 82) send_kind(KIND_MID);
        else if (pick < 97) send_kind(KIND_NOISE);
        else send_beat(CMD_START, 16'($urandom()), 16'($urandom()), 16'($urandom()));
        sent++;
      end
    end
  endtask

  task automatic test_random_phases();
    logic [15:0] p;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_all_regs(16'd0, 16'd0, 16'd1, 16'd1);
        1: write_all_regs(16'd32767, 16'd32767, 16'd65535, 16'd65535);
        2: write_all_regs(16'd32767, 16'd0, 16'd1, 16'd65535);
        default: begin
          p = 16'($urandom_range(16, 4000));
          write_all_regs(p, 16'($urandom_range(0, p)), 16'($urandom_range(1, 40)),
                         ($urandom_range(0, 4) == 0) ? 16'($urandom_range(100, 65535))
                                                     : 16'($urandom_range(1, 60)));
        end
      endcase
      stalls_on = (ph % 3 != 2);
      run_tap_sequences(48);
    end
  endtask

  // full-scale window and quiet period over a run of steady mid-level beats
  task automatic test_counter_saturation();
    write_all_regs(16'd128, 16'd64, 16'd65535, 16'd65535);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    send_beat(CMD_START, 16'sd0, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd200, 16'sd0, 16'sd0);
    repeat (40) send_beat(CMD_SAMPLE, 16'sd96, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
    send_beat(CMD_SAMPLE, 16'sd0, 16'sd200, 16'sd0);
  endtask

  always @(negedge clk) begin
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tap_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_taps_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: done %0b taps %0d armed %0b",
                   out_done_res, out_tap_count, out_armed);
      end else begin
        want = expected_taps_q.pop_front();
        if (out_done_res !== want.done || out_tap_count !== want.taps ||
            out_armed !== want.armed) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch (exp/act): done %0b/%0b taps %0d/%0d armed %0b/%0b",
                     want.done, out_done_res, want.taps, out_tap_count,
                     want.armed, out_armed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    press_th = 15'd128;
    release_th = 15'd64;
    window_ticks = 16'd500;
    rebase_ticks = 16'd2000;
    for (int i = 0; i < 3; i++) base_frc[i] = '0;
    tap_cnt = 2'd0;
    press_ok = 1'b1;
    ticks_since_press = '0;
    ticks_quiet = '0;
    double_tap = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    stalls_on = 1'b1;
    gaps_on = 1'b1;
    test_reset_defaults();
    test_force_extremes();
    test_zero_windows();
    test_random_phases();
    test_counter_saturation();
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
